>>> rtl/core/prvs_pkg.sv
// Shared constants, codes and control types of the page replacement victim selector.
package prvs_pkg;

  localparam int FRAMES    = 64;
  localparam int PAGE_BITS = 20;
  localparam int AGE_BITS  = 8;
  localparam int IDX_W     = $clog2(FRAMES);
  localparam int CNT_W     = IDX_W + 1;

  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_EVICT  = 2'd2;
  localparam logic [1:0] CMD_LOAD   = 2'd3;

  localparam logic [1:0] MODE_AGING = 2'd0;
  localparam logic [1:0] MODE_NRU   = 2'd1;

  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_ACCESS     = 4'd1;
  localparam logic [3:0] OP_LOAD       = 4'd2;
  localparam logic [3:0] OP_CLR_REF    = 4'd3;
  localparam logic [3:0] OP_SWEEP_INIT = 4'd4;
  localparam logic [3:0] OP_TICK_STEP  = 4'd5;
  localparam logic [3:0] OP_SCAN_STEP  = 4'd6;
  localparam logic [3:0] OP_VIC        = 4'd7;
  localparam logic [3:0] OP_FIND_STEP  = 4'd8;
  localparam logic [3:0] OP_HEAD_POP   = 4'd9;
  localparam logic [3:0] OP_SH_RD      = 4'd10;
  localparam logic [3:0] OP_SH_WR      = 4'd11;
  localparam logic [3:0] OP_SH_END     = 4'd12;
  localparam logic [3:0] OP_SC_ROT     = 4'd13;
  localparam logic [3:0] OP_SC_TAKE    = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic       emit;
    logic       emit_vic;
  } prvs_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       any_valid;
    logic       sweep_done;
    logic       find_hit;
    logic       sc_ref;
    logic       pos_zero;
    logic       sh_more;
    logic       out_busy;
  } prvs_stat_t;

endpackage

>>> rtl/core/prvs_ctrl.sv
// Controller state machine sequencing each command word through the datapath.
module prvs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          mode,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  prvs_pkg::prvs_stat_t stat,
  output prvs_pkg::prvs_cmd_t  cmd
);
  import prvs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_TICK   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_FIND   = 4'd4;
  localparam logic [3:0] S_SC_RD  = 4'd5;
  localparam logic [3:0] S_SC_CHK = 4'd6;
  localparam logic [3:0] S_SC_VIC = 4'd7;
  localparam logic [3:0] S_RMV    = 4'd8;
  localparam logic [3:0] S_SH_RD  = 4'd9;
  localparam logic [3:0] S_SH_WR  = 4'd10;

  logic [3:0] state, state_next;

  assign s_tready = (state == S_IDLE) && !stat.out_busy;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.emit     = 1'b0;
    cmd.emit_vic = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) state_next = S_DISP;
      end
      S_DISP: begin
        state_next = S_IDLE;
        case (stat.cmd)
          CMD_ACCESS: begin
            cmd.op   = OP_ACCESS;
            cmd.emit = 1'b1;
          end
          CMD_TICK: begin
            if (mode == MODE_AGING) begin
              cmd.op     = OP_SWEEP_INIT;
              state_next = S_TICK;
            end else begin
              if (mode == MODE_NRU) cmd.op = OP_CLR_REF;
              cmd.emit = 1'b1;
            end
          end
          CMD_EVICT: begin
            if (!stat.any_valid) begin
              cmd.emit = 1'b1;
            end else if (mode == MODE_AGING || mode == MODE_NRU) begin
              cmd.op     = OP_SWEEP_INIT;
              state_next = S_SCAN;
            end else begin
              state_next = S_SC_RD;
            end
          end
          default: begin
            cmd.op   = OP_LOAD;
            cmd.emit = 1'b1;
          end
        endcase
      end
      S_TICK: begin
        if (stat.sweep_done) begin
          cmd.op     = OP_CLR_REF;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_TICK_STEP;
        end
      end
      S_SCAN: begin
        if (stat.sweep_done) begin
          cmd.op     = OP_VIC;
          state_next = S_FIND;
        end else begin
          cmd.op = OP_SCAN_STEP;
        end
      end
      S_FIND: begin
        cmd.op = OP_FIND_STEP;
        if (stat.find_hit) state_next = S_RMV;
      end
      S_SC_RD: state_next = S_SC_CHK;
      S_SC_CHK: begin
        if (stat.sc_ref) begin
          cmd.op     = OP_SC_ROT;
          state_next = S_SC_RD;
        end else begin
          cmd.op     = OP_SC_TAKE;
          state_next = S_SC_VIC;
        end
      end
      S_SC_VIC: begin
        cmd.op     = OP_VIC;
        state_next = S_RMV;
      end
      S_RMV: begin
        if (stat.pos_zero) begin
          cmd.op       = OP_HEAD_POP;
          cmd.emit     = 1'b1;
          cmd.emit_vic = 1'b1;
          state_next   = S_IDLE;
        end else if (stat.sh_more) begin
          state_next = S_SH_RD;
        end else begin
          cmd.op       = OP_SH_END;
          cmd.emit     = 1'b1;
          cmd.emit_vic = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SH_RD: begin
        cmd.op     = OP_SH_RD;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.op     = OP_SH_WR;
        state_next = S_RMV;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/prvs_dp.sv
// Datapath: frame table, age and page memories, frame queue and result register.
module prvs_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    mode,
  input  logic                          s_accept,
  input  logic [1:0]                    in_cmd,
  input  logic [prvs_pkg::IDX_W-1:0]    in_frame,
  input  logic                          in_write,
  input  logic [prvs_pkg::PAGE_BITS-1:0] in_tag,
  input  prvs_pkg::prvs_cmd_t           cmd,
  output prvs_pkg::prvs_stat_t          stat,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic                          res_found,
  output logic [prvs_pkg::IDX_W-1:0]    res_frame,
  output logic [prvs_pkg::PAGE_BITS-1:0] res_page
);
  import prvs_pkg::*;

  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [AGE_BITS-1:0]  age_mem  [FRAMES];
  logic [IDX_W-1:0]     fifo_mem [FRAMES];

  logic [FRAMES-1:0]    valid, refb, modb;
  logic [1:0]           cmd_r;
  logic [IDX_W-1:0]     fi_r;
  logic                 wr_r;
  logic [PAGE_BITS-1:0] tag_r;
  logic [IDX_W-1:0]     head;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     cnt;
  logic                 d_vld;
  logic [IDX_W-1:0]     d_idx;
  logic                 found_r;
  logic [AGE_BITS-1:0]  best;
  logic [IDX_W-1:0]     vic;
  logic [IDX_W-1:0]     pos;
  logic [AGE_BITS-1:0]  age_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [IDX_W-1:0]     fifo_q;

  logic [IDX_W-1:0]     age_ra, age_wa, fifo_ra, fifo_wa;
  logic [AGE_BITS-1:0]  age_wd, key;
  logic [IDX_W-1:0]     fifo_wd;
  logic                 age_we, fifo_we, cnt_live, hit;
  logic [CNT_W-1:0]     pos_ext;

  assign cnt_live = (cnt < CNT_W'(FRAMES));
  assign key      = (mode == MODE_AGING) ? age_q : AGE_BITS'({refb[d_idx], modb[d_idx]});
  assign hit      = d_vld && (fifo_q == vic);
  assign pos_ext  = {1'b0, pos};

  assign stat.cmd        = cmd_r;
  assign stat.any_valid  = |valid;
  assign stat.sweep_done = !cnt_live && !d_vld;
  assign stat.find_hit   = hit;
  assign stat.sc_ref     = refb[fifo_q];
  assign stat.pos_zero   = (pos == '0);
  assign stat.sh_more    = (pos_ext + CNT_W'(1)) < count;
  assign stat.out_busy   = m_tvalid;

  always_comb begin
    age_ra  = cnt[IDX_W-1:0];
    age_we  = 1'b0;
    age_wa  = d_idx;
    age_wd  = {refb[d_idx], age_q[AGE_BITS-1:1]};
    fifo_ra = head;
    fifo_we = 1'b0;
    fifo_wa = head + count[IDX_W-1:0];
    fifo_wd = fi_r;
    case (cmd.op)
      OP_LOAD: begin
        if (!valid[fi_r]) begin
          age_we  = 1'b1;
          age_wa  = fi_r;
          age_wd  = '0;
          fifo_we = 1'b1;
        end
      end
      OP_TICK_STEP: age_we = d_vld;
      OP_VIC: begin
        age_we = 1'b1;
        age_wa = vic;
        age_wd = '0;
      end
      OP_FIND_STEP: fifo_ra = head + cnt[IDX_W-1:0];
      OP_SH_RD:     fifo_ra = head + pos + IDX_W'(1);
      OP_SH_WR: begin
        fifo_we = 1'b1;
        fifo_wa = head + pos;
        fifo_wd = fifo_q;
      end
      OP_SC_ROT: begin
        fifo_we = 1'b1;
        fifo_wd = fifo_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    age_q <= age_mem[age_ra];
    if (age_we) age_mem[age_wa] <= age_wd;
    fifo_q <= fifo_mem[fifo_ra];
    if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
    page_q <= page_mem[vic];
    if (cmd.op == OP_LOAD) page_mem[fi_r] <= tag_r;
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      cmd_r <= in_cmd;
      fi_r  <= in_frame;
      wr_r  <= in_write;
      tag_r <= in_tag;
    end
    if (cmd.emit) begin
      res_found <= cmd.emit_vic;
      res_frame <= cmd.emit_vic ? vic : '0;
      res_page  <= cmd.emit_vic ? page_q : '0;
    end
    case (cmd.op)
      OP_SWEEP_INIT: begin
        cnt     <= '0;
        found_r <= 1'b0;
      end
      OP_TICK_STEP, OP_SCAN_STEP, OP_FIND_STEP: begin
        d_idx <= cnt[IDX_W-1:0];
        if (cnt_live) cnt <= cnt + CNT_W'(1);
        if (cmd.op == OP_SCAN_STEP && d_vld && valid[d_idx] && (!found_r || key < best)) begin
          found_r <= 1'b1;
          best    <= key;
          vic     <= d_idx;
        end
        if (cmd.op == OP_FIND_STEP && hit) pos <= d_idx;
      end
      OP_VIC: begin
        cnt <= '0;
        pos <= '0;
      end
      OP_SH_WR: pos <= pos + IDX_W'(1);
      OP_SC_TAKE: vic <= fifo_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      refb     <= '0;
      modb     <= '0;
      head     <= '0;
      count    <= '0;
      d_vld    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (cmd.op)
        OP_ACCESS: begin
          if (valid[fi_r]) begin
            refb[fi_r] <= 1'b1;
            if (wr_r) modb[fi_r] <= 1'b1;
          end
        end
        OP_LOAD: begin
          if (!valid[fi_r]) count <= count + CNT_W'(1);
          valid[fi_r] <= 1'b1;
          refb[fi_r]  <= 1'b1;
          modb[fi_r]  <= wr_r;
        end
        OP_CLR_REF:    refb  <= '0;
        OP_SWEEP_INIT: d_vld <= 1'b0;
        OP_TICK_STEP, OP_SCAN_STEP, OP_FIND_STEP: d_vld <= cnt_live;
        OP_VIC: begin
          d_vld      <= 1'b0;
          valid[vic] <= 1'b0;
          refb[vic]  <= 1'b0;
          modb[vic]  <= 1'b0;
        end
        OP_HEAD_POP: begin
          head  <= head + IDX_W'(1);
          count <= count - CNT_W'(1);
        end
        OP_SH_END: count <= count - CNT_W'(1);
        OP_SC_ROT: begin
          refb[fifo_q] <= 1'b0;
          head         <= head + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/page_replacement_victim_selector_core.sv
// Top level of the page replacement victim selector: ports, policy register, wiring.
//
// Input words arrive on s_tvalid/s_tready with the command in s_tuser and the
// frame index, write flag and page tag in s_tdata. Every input word yields
// exactly one result word on m_tvalid/m_tready: victim flag, frame and page.
// Access, load and a tick outside aging mode are done in the dispatch state,
// which writes the result register; the next word is taken once that result
// has been accepted. A tick in aging mode sweeps the age memory, one frame a
// cycle. An evict in aging or NRU mode scans all frames, then searches the
// frame queue one slot a cycle with registered read data and closes the gap
// through a read state and a write state per moved entry; a victim at the
// queue head is popped without moving entries. Second chance inspects queue
// entries from the head through a read state and a check state. The queue
// memory reads one slot a cycle with registered data. A new word is taken
// only when the block is idle and the result register is empty; a stalled
// receiver therefore holds the input side. Reset empties the frame table and
// queue and sets the policy to aging; no clearing pass is needed. The policy
// register answers at APB addresses 0 to 3, decoded from paddr[2] alone.
module page_replacement_victim_selector_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [5:0] frame_index, [6] is_write, [26:7] page_tag
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] victim_found, [6:1] victim_frame, [26:7] victim_page
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import prvs_pkg::*;

  prvs_cmd_t            cmd;
  prvs_stat_t           stat;
  logic [1:0]           policy_mode;
  logic                 res_found;
  logic [IDX_W-1:0]     res_frame;
  logic [PAGE_BITS-1:0] res_page;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, policy_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= MODE_AGING;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      policy_mode <= pwdata[1:0];
    end
  end

  assign m_tdata = {5'd0, res_page, res_frame, res_found};

  prvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .mode     (policy_mode),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prvs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .mode      (policy_mode),
    .s_accept  (s_tvalid && s_tready),
    .in_cmd    (s_tuser),
    .in_frame  (s_tdata[5:0]),
    .in_write  (s_tdata[6]),
    .in_tag    (s_tdata[26:7]),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .res_found (res_found),
    .res_frame (res_frame),
    .res_page  (res_page)
  );

endmodule

>>> bench/tb.sv
// Self-checking bench for the page replacement victim selector core.
`timescale 1ns / 100ps

module tb;
  import prvs_pkg::*;

  localparam logic [1:0] MODE_FIFO  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  frame;
    logic        wr;
    logic [19:0] tag;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  frame;
    logic [19:0] page;
  } vic_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = 0;
  logic [1:0]  s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  page_replacement_victim_selector_core dut (.*);

  // predictor state
  logic [1:0]  mode;
  logic [19:0] pg [FRAMES];
  logic        vld [FRAMES];
  logic        rb [FRAMES];
  logic        mb [FRAMES];
  logic [7:0]  age [FRAMES];
  logic [5:0]  fq [$];

  req_t pending_reqs [$];
  vic_t victims_due [$];
  int   errors = 0;
  int   send_idle = 0, recv_idle = 0;
  int   phase = -1;
  int   hold_cnt = 0;
  logic holding = 0;

  function automatic vic_t predict_victim(req_t r);
    vic_t o;
    int v;
    int best;
    int c;
    logic [5:0] f;
    o = '0;
    v = -1;
    case (r.cmd)
      CMD_ACCESS: if (vld[r.frame]) begin
        rb[r.frame] = 1;
        if (r.wr) mb[r.frame] = 1;
      end
      CMD_TICK: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (mode == MODE_AGING) begin
            age[i] = {rb[i], age[i][7:1]};
            rb[i] = 0;
          end else if (mode == MODE_NRU) begin
            rb[i] = 0;
          end
        end
      end
      CMD_EVICT: begin
        if (mode == MODE_AGING) begin
          best = 1000;
          for (int i = 0; i < FRAMES; i++)
            if (vld[i] && age[i] < best) begin best = age[i]; v = i; end
        end else if (mode == MODE_NRU) begin
          best = 1000;
          for (int i = 0; i < FRAMES; i++) begin
            c = 2 * rb[i] + mb[i];
            if (vld[i] && c < best) begin best = c; v = i; end
          end
        end else begin
          while (fq.size() > 0 && v < 0) begin
            f = fq[0];
            if (!rb[f]) v = f;
            else begin
              rb[f] = 0;
              void'(fq.pop_front());
              fq.push_back(f);
            end
          end
        end
        if (v >= 0) begin
          o.found = 1;
          o.frame = 6'(v);
          o.page = pg[v];
          vld[v] = 0; rb[v] = 0; mb[v] = 0; age[v] = 0;
          for (int k = 0; k < fq.size(); k++)
            if (fq[k] == v) begin fq.delete(k); break; end
        end
      end
      default: begin
        if (!vld[r.frame]) begin
          age[r.frame] = 0;
          fq.push_back(r.frame);
        end
        pg[r.frame] = r.tag;
        vld[r.frame] = 1;
        rb[r.frame] = 1;
        mb[r.frame] = r.wr;
      end
    endcase
    return o;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        victims_due.push_back(predict_victim(pending_reqs.pop_front()));
      end
      if ((!s_tvalid || s_tready) ) begin
        if (pending_reqs.size() > (s_tvalid && s_tready ? 0 : 0) &&
            $urandom_range(99) >= send_idle) begin
          s_tvalid <= 1;
          s_tuser <= pending_reqs[0].cmd;
          s_tdata <= {5'd0, pending_reqs[0].tag, pending_reqs[0].wr, pending_reqs[0].frame};
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // long receiver stall
  always @(posedge clk) begin
    if (phase == 1 && hold_cnt < 400) begin
      holding  <= 1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      holding <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    vic_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[6:1], m_tdata[26:7]};
        if (victims_due.size() == 0) begin
          $display("%0t unexpected word %h", $time, got);
          errors++;
        end else begin
          want = victims_due.pop_front();
          if (got !== want || m_tdata[31:27] !== 0) begin
            $display("%0t mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      if (holding) begin
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || s_tvalid || victims_due.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= {30'd0, m};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    mode = m;
  endtask

  function automatic req_t rand_req(int frames_in_use);
    req_t r;
    int p;
    p = $urandom_range(99);
    r.cmd = p < 35 ? CMD_ACCESS : p < 50 ? CMD_TICK : p < 72 ? CMD_EVICT : CMD_LOAD;
    r.frame = 6'($urandom_range(frames_in_use - 1));
    if ($urandom_range(9) == 0) r.frame = 6'($urandom_range(63));
    r.wr = 1'($urandom_range(1));
    r.tag = 20'($urandom);
    return r;
  endfunction

  function automatic req_t mk(logic [1:0] c, logic [5:0] f, logic w, logic [19:0] t);
    req_t r;
    r.cmd = c; r.frame = f; r.wr = w; r.tag = t;
    return r;
  endfunction

  initial begin
    mode = MODE_AGING;
    for (int i = 0; i < FRAMES; i++) begin
      pg[i] = 0; vld[i] = 0; rb[i] = 0; mb[i] = 0; age[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 0;
    // directed
    pending_reqs.push_back(mk(CMD_EVICT, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_ACCESS, 5, 1, 0));
    pending_reqs.push_back(mk(CMD_LOAD, 0, 0, 20'h00000));
    pending_reqs.push_back(mk(CMD_LOAD, 63, 1, 20'hFFFFF));
    pending_reqs.push_back(mk(CMD_LOAD, 7, 0, 20'h5A5A5));
    pending_reqs.push_back(mk(CMD_TICK, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_ACCESS, 63, 1, 0));
    pending_reqs.push_back(mk(CMD_TICK, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_LOAD, 63, 0, 20'hABCDE));
    pending_reqs.push_back(mk(CMD_EVICT, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_EVICT, 0, 0, 0));
    wait_drain();
    write_mode(MODE_NRU);
    pending_reqs.push_back(mk(CMD_LOAD, 3, 1, 20'h12345));
    pending_reqs.push_back(mk(CMD_LOAD, 4, 0, 20'h54321));
    pending_reqs.push_back(mk(CMD_TICK, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_ACCESS, 4, 0, 0));
    pending_reqs.push_back(mk(CMD_EVICT, 0, 0, 0));
    wait_drain();
    write_mode(MODE_FIFO);
    pending_reqs.push_back(mk(CMD_LOAD, 9, 1, 20'h0F0F0));
    pending_reqs.push_back(mk(CMD_ACCESS, 4, 1, 0));
    pending_reqs.push_back(mk(CMD_EVICT, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_TICK, 0, 0, 0));
    wait_drain();
    write_mode(MODE_SPARE);
    pending_reqs.push_back(mk(CMD_EVICT, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_EVICT, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_EVICT, 0, 0, 0));
    wait_drain();
    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(2'(ph % 4));
      case (ph % 4)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 49; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 49; end
        default: begin send_idle = 18; recv_idle = 18; end
      endcase
      phase = ph;
      for (int n = 0; n < 80; n++)
        pending_reqs.push_back(rand_req(ph < 4 ? 16 : 64));
      wait_drain();
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/prvs_pkg.sv
rtl/core/prvs_ctrl.sv
rtl/core/prvs_dp.sv
rtl/core/page_replacement_victim_selector_core.sv
bench/tb.sv
